// ===== src/ssi_angle_frame_checker_unit_assert.svh =====
// Assertion macros for the SSI angle frame checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SSI_ANGLE_FRAME_CHECKER_UNIT_ASSERT_SVH
`define SSI_ANGLE_FRAME_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SAFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("safc assertion failed");

// Next-cycle implication.
`define SAFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("safc assertion failed");

`endif

// ===== src/safc_pkg.sv =====
// Package for the SSI angle frame checker: link states, probe limits, CRC6 logic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package safc_pkg;

    typedef enum logic [1:0] {
        LINK_PROBING = 2'd0,
        LINK_READY   = 2'd1,
        LINK_FAILED  = 2'd2
    } link_state_t;

    localparam int FRAME_W  = 24;
    localparam int DATA_W   = 18;
    localparam int CRC_W    = 6;
    localparam int ANGLE_W  = 14;
    localparam int STATUS_W = 4;

    localparam logic [3:0] PROBE_ATTEMPTS     = 4'd10;
    localparam logic [1:0] PROBE_VALID_NEEDED = 2'd3;

    // Contribution of data bit k (x^6+x+1, zero init, MSB first) to the CRC.
    localparam logic [CRC_W-1:0] CRC_COL [DATA_W] = '{
        6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h23, 6'h05, 6'h0A, 6'h14,
        6'h28, 6'h13, 6'h26, 6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29
    };

    function automatic logic [CRC_W-1:0] crc6_calc(input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = '0;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (data[k])
            begin
                crc = crc ^ CRC_COL[k];
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== src/ssi_angle_frame_checker_unit.sv =====
// A frame item passes the input register, then the result register.
// Throughput: one item per cycle unless result_stall holds; the CRC6 and
// probe/status update are one combinational pass between the two registers.
// Reset (rst_n low, asynchronous): both stages empty, link probing,
// probe counters and kept status cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "ssi_angle_frame_checker_unit_assert.svh"

module ssi_angle_frame_checker_unit #(
    parameter logic [3:0] PROBE_ATTEMPTS     = safc_pkg::PROBE_ATTEMPTS,
    parameter logic [1:0] PROBE_VALID_NEEDED = safc_pkg::PROBE_VALID_NEEDED
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire logic [23:0] frame_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             crc_ok,
    output logic [13:0]      angle_count,
    output logic             track_loss,
    output logic             push_button,
    output logic [1:0]       field_status,
    output logic             status_changed,
    output logic [1:0]       link_state
);

    logic                          in_valid_reg;
    logic [safc_pkg::FRAME_W-1:0]  frame_reg;
    logic                          out_valid_reg;
    logic                          crc_ok_reg;
    logic [safc_pkg::ANGLE_W-1:0]  angle_reg;
    logic [safc_pkg::STATUS_W-1:0] status_reg;
    logic                          changed_reg;
    safc_pkg::link_state_t         link_reg;

    safc_pkg::link_state_t         state_reg, state_next;
    logic [3:0]                    attempts_reg, attempts_next;
    logic [1:0]                    pvalid_reg, pvalid_next;
    logic                          nonzero_reg, nonzero_next;
    logic [safc_pkg::STATUS_W-1:0] last_status_reg, last_status_next;
    logic                          seen_reg, seen_next;

    logic                          advance;
    logic                          in_load;
    logic                          ok;
    logic [safc_pkg::ANGLE_W-1:0]  angle;
    logic [safc_pkg::STATUS_W-1:0] status;
    logic                          changed;

    assign advance     = in_valid_reg && (!out_valid_reg || !result_stall);
    assign frame_stall = in_valid_reg && !advance;
    assign in_load     = !frame_stall;

    always_comb
    begin
        ok = (safc_pkg::crc6_calc(frame_reg[23:6]) == frame_reg[5:0]);
        angle  = ok ? frame_reg[23:10] : '0;
        status = ok ? frame_reg[9:6] : '0;
        changed          = 1'b0;
        state_next       = state_reg;
        attempts_next    = attempts_reg;
        pvalid_next      = pvalid_reg;
        nonzero_next     = nonzero_reg;
        last_status_next = last_status_reg;
        seen_next        = seen_reg;
        case (state_reg)
            safc_pkg::LINK_PROBING:
            begin
                if (attempts_reg != 4'hF)
                begin
                    attempts_next = attempts_reg + 4'd1;
                end
                if (ok)
                begin
                    if (pvalid_reg != 2'd3)
                    begin
                        pvalid_next = pvalid_reg + 2'd1;
                    end
                    if (angle != '0)
                    begin
                        nonzero_next = 1'b1;
                    end
                end
                if (pvalid_next >= PROBE_VALID_NEEDED && nonzero_next)
                begin
                    state_next = safc_pkg::LINK_READY;
                end
                else if (attempts_next >= PROBE_ATTEMPTS)
                begin
                    state_next = safc_pkg::LINK_FAILED;
                end
            end
            safc_pkg::LINK_READY:
            begin
                if (ok && (!seen_reg || status != last_status_reg))
                begin
                    changed          = 1'b1;
                    last_status_next = status;
                    seen_next        = 1'b1;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= safc_pkg::LINK_PROBING;
            attempts_reg    <= '0;
            pvalid_reg      <= '0;
            nonzero_reg     <= 1'b0;
            last_status_reg <= '0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= frame_valid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                state_reg       <= state_next;
                attempts_reg    <= attempts_next;
                pvalid_reg      <= pvalid_next;
                nonzero_reg     <= nonzero_next;
                last_status_reg <= last_status_next;
                seen_reg        <= seen_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && in_load)
        begin
            frame_reg <= frame_word;
        end
        if (advance)
        begin
            crc_ok_reg  <= ok;
            angle_reg   <= angle;
            status_reg  <= status;
            changed_reg <= changed;
            link_reg    <= state_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign crc_ok         = crc_ok_reg;
    assign angle_count    = angle_reg;
    assign track_loss     = status_reg[3];
    assign push_button    = status_reg[2];
    assign field_status   = status_reg[1:0];
    assign status_changed = changed_reg;
    assign link_state     = link_reg;

    `SAFC_ASSERT_NOW(a_changed_needs_ready, out_valid_reg && changed_reg,
        crc_ok_reg && link_reg == safc_pkg::LINK_READY)
    `SAFC_ASSERT_NEXT(a_failed_sticks, state_reg == safc_pkg::LINK_FAILED,
        state_reg == safc_pkg::LINK_FAILED)
    `SAFC_ASSERT_NOW(a_probe_bounded, state_reg == safc_pkg::LINK_PROBING,
        attempts_reg < PROBE_ATTEMPTS)

endmodule

`default_nettype wire
